### src/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Types and constants shared by the random access response parser.
// ----------------------------------------------------------------------------
package rar_pkg;

   localparam int PAYLOAD_LEN = 6;
   localparam logic [6:0] NO_BEST = 7'd64;
   localparam logic [8:0] OFFSET_MAX = 9'd511;

   typedef enum logic [2:0] {
      ST_EXACT       = 3'd0,
      ST_CLOSEST     = 3'd1,
      ST_NO_RESPONSE = 3'd2,
      ST_TRUNCATED   = 3'd3,
      ST_SECONDARY   = 3'd4
   } rar_status_type;

   typedef enum logic {
      CSR_TARGET_PREAMBLE   = 1'b0,
      CSR_SECONDARY_CARRIER = 1'b1
   } rar_csr_type;

   typedef struct packed {
      rar_status_type status;
      logic [10:0]    timing_advance;
      logic [15:0]    temp_crnti;
      logic [7:0]     chosen_header;
      logic [47:0]    chosen_payload;
   } rar_result_type;

endpackage

### src/rar_core.sv
// ----------------------------------------------------------------------------
// rar_core
// Parse state of one response PDU: subheader matching, payload capture and
// the result computed on the final byte.
// ----------------------------------------------------------------------------
module rar_core import rar_pkg::*; #(
   parameter int MAX_SUBHEADERS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     pdu_byte,
   input  logic           pdu_last,
   input  logic [5:0]     target_preamble,
   input  logic           secondary_carrier,
   output rar_result_type result
);

   localparam logic [6:0] MaxSub = 7'(MAX_SUBHEADERS);

   logic        in_payload_ff, in_payload_in;
   logic [6:0]  sub_count_ff, sub_count_in;
   logic [6:0]  resp_count_ff, resp_count_in;
   logic [6:0]  best_dist_ff, best_dist_in;
   logic [5:0]  best_idx_ff, best_idx_in;
   logic [7:0]  best_header_ff, best_header_in;
   logic [8:0]  offset_ff, offset_in;
   logic [47:0] payload_ff, payload_in;
   logic [2:0]  captured_ff, captured_in;

   logic        u_in_payload;
   logic [6:0]  u_sub_count, u_resp_count, u_best_dist;
   logic [5:0]  u_best_idx;
   logic [7:0]  u_best_header;
   logic [8:0]  u_offset;
   logic [47:0] u_payload;
   logic [2:0]  u_captured;

   logic [5:0]  rapid, rapid_dist;
   logic [8:0]  start;
   logic        in_window;
   rar_status_type status;

   always_comb begin
      u_in_payload  = in_payload_ff;
      u_sub_count   = sub_count_ff;
      u_resp_count  = resp_count_ff;
      u_best_dist   = best_dist_ff;
      u_best_idx    = best_idx_ff;
      u_best_header = best_header_ff;
      u_offset      = offset_ff;
      u_payload     = payload_ff;
      u_captured    = captured_ff;

      rapid      = pdu_byte[5:0];
      rapid_dist = (rapid >= target_preamble) ? rapid - target_preamble
                                              : target_preamble - rapid;
      // start of the chosen response's payload: index * 6
      start = {1'b0, best_idx_ff, 2'b00} + {2'b00, best_idx_ff, 1'b0};
      in_window = (best_dist_ff < NO_BEST) && (offset_ff >= start)
                  && (offset_ff < start + 9'(PAYLOAD_LEN))
                  && (captured_ff < 3'(PAYLOAD_LEN));

      if (in_payload_ff) begin
         if (in_window) begin
            u_payload  = {payload_ff[39:0], pdu_byte};
            u_captured = captured_ff + 3'd1;
         end
         if (offset_ff < OFFSET_MAX) begin
            u_offset = offset_ff + 9'd1;
         end
      end else begin
         if (sub_count_ff < MaxSub) begin
            u_sub_count = sub_count_ff + 7'd1;
         end
         // backoff subheaders (T=0) only count towards the subheader total
         if (pdu_byte[6]) begin
            u_resp_count = resp_count_ff + 7'd1;
            if ({1'b0, rapid_dist} < best_dist_ff) begin
               u_best_dist   = {1'b0, rapid_dist};
               u_best_idx    = resp_count_ff[5:0];
               u_best_header = pdu_byte;
            end
         end
         if (!pdu_byte[7] || u_sub_count >= MaxSub) begin
            u_in_payload = 1'b1;
            u_offset     = '0;
         end
      end

      priority if (secondary_carrier) begin
         status = ST_SECONDARY;
      end else if (!u_in_payload) begin
         status = ST_TRUNCATED;
      end else if (u_best_dist >= NO_BEST) begin
         status = ST_NO_RESPONSE;
      end else if (u_captured < 3'(PAYLOAD_LEN)) begin
         status = ST_TRUNCATED;
      end else if (u_best_dist == 7'd0) begin
         status = ST_EXACT;
      end else begin
         status = ST_CLOSEST;
      end

      result = '0;
      result.status = status;
      if (status == ST_EXACT || status == ST_CLOSEST) begin
         result.timing_advance = {u_payload[46:40], u_payload[39:36]};
         result.chosen_header  = u_best_header;
         result.chosen_payload = u_payload;
         if (status == ST_EXACT) begin
            result.temp_crnti = u_payload[15:0];
         end
      end

      if (pdu_last) begin
         in_payload_in  = 1'b0;
         sub_count_in   = '0;
         resp_count_in  = '0;
         best_dist_in   = NO_BEST;
         best_idx_in    = '0;
         best_header_in = '0;
         offset_in      = '0;
         payload_in     = '0;
         captured_in    = '0;
      end else begin
         in_payload_in  = u_in_payload;
         sub_count_in   = u_sub_count;
         resp_count_in  = u_resp_count;
         best_dist_in   = u_best_dist;
         best_idx_in    = u_best_idx;
         best_header_in = u_best_header;
         offset_in      = u_offset;
         payload_in     = u_payload;
         captured_in    = u_captured;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff  <= 1'b0;
         sub_count_ff   <= '0;
         resp_count_ff  <= '0;
         best_dist_ff   <= NO_BEST;
         best_idx_ff    <= '0;
         best_header_ff <= '0;
         offset_ff      <= '0;
         payload_ff     <= '0;
         captured_ff    <= '0;
      end else if (take) begin
         in_payload_ff  <= in_payload_in;
         sub_count_ff   <= sub_count_in;
         resp_count_ff  <= resp_count_in;
         best_dist_ff   <= best_dist_in;
         best_idx_ff    <= best_idx_in;
         best_header_ff <= best_header_in;
         offset_ff      <= offset_in;
         payload_ff     <= payload_in;
         captured_ff    <= captured_in;
      end
   end

endmodule

### src/rar_pdu_parser.sv
// ----------------------------------------------------------------------------
// rar_pdu_parser
// LTE random access response MAC PDU parser, one byte per transaction.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                                   | handshake
//  req_     | in        | pdu_byte, pdu_last                        | valid/ready
//  rsp_     | out       | status, timing_advance, temp_crnti,       | valid/ready
//           |           | chosen_header, chosen_payload             |
//  csr_     | in        | index, data                               | valid/ready
//
//  One byte per cycle while req_ready is high; the parse state updates in the
//  cycle the byte is taken. The result of a PDU appears in the cycle after its
//  last byte is taken, held in the output register until taken. req_ready drops
//  only while a result is held and rsp_ready is low. Reset clears parse state,
//  the csr registers and the result valid flag; csr writes are always accepted.
// ----------------------------------------------------------------------------
module rar_pdu_parser import rar_pkg::*; #(
   parameter int MAX_SUBHEADERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pdu_byte,
   input  logic        req_pdu_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_timing_advance,
   output logic [15:0] rsp_temp_crnti,
   output logic [7:0]  rsp_chosen_header,
   output logic [47:0] rsp_chosen_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   logic [5:0]     target_ff;
   logic           secondary_ff;
   logic           take;
   rar_result_type result;
   rar_result_type rsp_ff;
   logic           rsp_valid_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         secondary_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (rar_csr_type'(csr_index))
            CSR_TARGET_PREAMBLE: begin
               target_ff <= csr_data;
            end
            CSR_SECONDARY_CARRIER: begin
               secondary_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   rar_core #(
      .MAX_SUBHEADERS(MAX_SUBHEADERS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .take              (take),
      .pdu_byte          (req_pdu_byte),
      .pdu_last          (req_pdu_last),
      .target_preamble   (target_ff),
      .secondary_carrier (secondary_ff),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_pdu_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_pdu_last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_timing_advance = rsp_ff.timing_advance;
   assign rsp_temp_crnti     = rsp_ff.temp_crnti;
   assign rsp_chosen_header  = rsp_ff.chosen_header;
   assign rsp_chosen_payload = rsp_ff.chosen_payload;

endmodule

### src/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker
// Port-level checks on the response parser, bound to the top level.
// ----------------------------------------------------------------------------
module rar_checker import rar_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_pdu_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [10:0] rsp_timing_advance,
   input logic [15:0] rsp_temp_crnti,
   input logic [7:0]  rsp_chosen_header,
   input logic [47:0] rsp_chosen_payload
);

   // a final byte always produces a result in the next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_pdu_last |=> rsp_valid)
      else $error("no result after final byte");

   // no result appears without a final byte
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_pdu_last) |=> !rsp_valid)
      else $error("result without final byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_chosen_payload))
      else $error("stalled result changed");

   // C-RNTI only reported for an exact match
   a_crnti_exact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EXACT |-> rsp_temp_crnti == 16'd0)
      else $error("temp C-RNTI without exact match");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EXACT && rsp_status != ST_CLOSEST
      |-> rsp_chosen_header == 8'd0 && rsp_timing_advance == 11'd0)
      else $error("error status with non-zero fields");

endmodule

bind rar_pdu_parser rar_checker u_checker (.*);
